// ===== rtl/teq_pkg.sv =====
// Package for the timed event queue: entry record, kinds, states and defaults.
// Used by timed_event_queue and the testbench; depends on nothing.
package teq_pkg;

    localparam int QueueDepthDefault = 64;

    typedef struct packed {
        logic [31:0] time_s;
        logic [15:0] ev_type;
        logic [31:0] param_one;
        logic [31:0] param_two;
        logic [31:0] handle_one;
        logic [31:0] handle_two;
    } t_entry;

    localparam int EntryWidth = $bits(t_entry);

    localparam logic [1:0] KIND_ACCEPTED = 2'd0;
    localparam logic [1:0] KIND_FULL     = 2'd1;
    localparam logic [1:0] KIND_DUE      = 2'd2;
    localparam logic [1:0] KIND_NONE     = 2'd3;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_TCK_RD,
        ST_TCK_CMP
    } t_state;

endpackage

// ===== rtl/teq_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; no package needed.
module teq_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// ===== rtl/timed_event_queue.sv =====
// Timed event queue top level: sorted circular store in one RAM plus sequencer.
// Depends on teq_pkg and teq_ram.
//
//  channel  | handshake                 | payload
//  request  | start in, busy out        | i_command, i_event_time .. i_handle_two
//  result   | o_strobe out, one cycle   | o_kind, o_due_time .. o_handle_two, o_last
//
// An insert keeps busy high while it moves each stored event later than the new one up one
// place and writes the new event into the gap; a full store keeps busy low.
// A tick keeps busy high while it releases each due event from the head, and ends at the
// first undue entry or when the store runs empty.
// Reset empties the store at once; the RAM contents need no clearing.
// Results cannot be stalled; each request's last result appears as busy falls.
module timed_event_queue
    import teq_pkg::*;
#(
    parameter int QueueDepth = QueueDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_command,
    input  logic [31:0] i_event_time,
    input  logic [15:0] i_event_type,
    input  logic signed [31:0] i_param_one,
    input  logic signed [31:0] i_param_two,
    input  logic [31:0] i_handle_one,
    input  logic [31:0] i_handle_two,
    output logic        o_strobe,
    output logic [1:0]  o_kind,
    output logic [31:0] o_due_time,
    output logic [15:0] o_out_type,
    output logic signed [31:0] o_out_param_one,
    output logic signed [31:0] o_out_param_two,
    output logic [31:0] o_out_handle_one,
    output logic [31:0] o_out_handle_two,
    output logic        o_last
);
    localparam int AW = $clog2(QueueDepth);
    localparam int CW = $clog2(QueueDepth + 1);
    localparam logic [AW-1:0] LastAddr = AW'(QueueDepth - 1);
    localparam logic [CW-1:0] FullCount = CW'(QueueDepth);

    function automatic logic [AW-1:0] inc_a(input logic [AW-1:0] a);
        return (a == LastAddr) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [AW-1:0] dec_a(input logic [AW-1:0] a);
        return (a == '0) ? LastAddr : a - 1'b1;
    endfunction

    t_state         r_state, n_state;
    t_entry         r_req, n_req;
    logic [AW-1:0]  r_head, n_head, r_tail, n_tail, r_rp, n_rp, r_wp, n_wp;
    logic [CW-1:0]  r_count, n_count, r_left, n_left;
    t_entry         r_pend, n_pend;
    logic           r_have, n_have;
    logic           r_stb, n_stb, r_last, n_last;
    logic [1:0]     r_kind, n_kind;
    t_entry         r_out, n_out;

    logic           we;
    logic [AW-1:0]  waddr, raddr;
    t_entry         wdata, rdata;

    teq_ram #(.Width(EntryWidth), .Depth(QueueDepth)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_have  <= 1'b0;
            r_stb   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_have  <= n_have;
            r_stb   <= n_stb;
        end
        r_req  <= n_req;
        r_rp   <= n_rp;
        r_wp   <= n_wp;
        r_left <= n_left;
        r_pend <= n_pend;
        r_last <= n_last;
        r_kind <= n_kind;
        r_out  <= n_out;
    end

    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_rp    = r_rp;
        n_wp    = r_wp;
        n_left  = r_left;
        n_pend  = r_pend;
        n_have  = r_have;
        n_stb   = 1'b0;
        n_last  = 1'b1;
        n_kind  = KIND_NONE;
        n_out   = '0;
        we      = 1'b0;
        waddr   = r_wp;
        wdata   = r_req;
        raddr   = r_rp;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_req = '{i_event_time, i_event_type, i_param_one, i_param_two,
                              i_handle_one, i_handle_two};
                    n_have = 1'b0;
                    n_rp   = r_head;
                    if (i_command == CMD_TICK) begin
                        n_state = ST_TCK_RD;
                    end else if (r_count == FullCount) begin
                        n_stb  = 1'b1;
                        n_kind = KIND_FULL;
                    end else begin
                        n_wp    = r_tail;
                        n_rp    = dec_a(r_tail);
                        n_left  = r_count;
                        n_state = ST_INS_RD;
                    end
                end
            end
            ST_INS_RD: begin
                if (r_left == '0) begin
                    we      = 1'b1;
                    n_tail  = inc_a(r_tail);
                    n_count = r_count + 1'b1;
                    n_stb   = 1'b1;
                    n_kind  = KIND_ACCEPTED;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_INS_CMP;
                end
            end
            ST_INS_CMP: begin
                we = 1'b1;
                if (rdata.time_s > r_req.time_s) begin
                    wdata   = rdata;
                    n_wp    = r_rp;
                    n_rp    = dec_a(r_rp);
                    n_left  = r_left - 1'b1;
                    n_state = ST_INS_RD;
                end else begin
                    n_tail  = inc_a(r_tail);
                    n_count = r_count + 1'b1;
                    n_stb   = 1'b1;
                    n_kind  = KIND_ACCEPTED;
                    n_state = ST_IDLE;
                end
            end
            ST_TCK_RD: begin
                if (r_count == '0) begin
                    n_stb   = 1'b1;
                    n_kind  = r_have ? KIND_DUE : KIND_NONE;
                    n_out   = r_have ? r_pend : '0;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_TCK_CMP;
                end
            end
            ST_TCK_CMP: begin
                if (rdata.time_s <= r_req.time_s) begin
                    n_stb   = r_have;
                    n_kind  = KIND_DUE;
                    n_out   = r_pend;
                    n_last  = 1'b0;
                    n_pend  = rdata;
                    n_have  = 1'b1;
                    n_head  = inc_a(r_head);
                    n_rp    = inc_a(r_head);
                    n_count = r_count - 1'b1;
                    n_state = ST_TCK_RD;
                end else begin
                    n_stb   = 1'b1;
                    n_kind  = r_have ? KIND_DUE : KIND_NONE;
                    n_out   = r_have ? r_pend : '0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy             = (r_state != ST_IDLE);
    assign o_strobe         = r_stb;
    assign o_kind           = r_kind;
    assign o_last           = r_last;
    assign o_due_time       = r_out.time_s;
    assign o_out_type       = r_out.ev_type;
    assign o_out_param_one  = r_out.param_one;
    assign o_out_param_two  = r_out.param_two;
    assign o_out_handle_one = r_out.handle_one;
    assign o_out_handle_two = r_out.handle_two;
endmodule

// ===== dv/teq_checker.sv =====
// Checker for the timed event queue: watches accepted requests and results,
// keeps its own sorted event store and compares every result. Depends on teq_pkg.
`timescale 1ns / 100ps
module teq_checker
    import teq_pkg::*;
#(
    parameter int Depth = QueueDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        i_command,
    input  logic [31:0] i_event_time,
    input  logic [15:0] i_event_type,
    input  logic signed [31:0] i_param_one,
    input  logic signed [31:0] i_param_two,
    input  logic [31:0] i_handle_one,
    input  logic [31:0] i_handle_two,
    input  logic        o_strobe,
    input  logic [1:0]  o_kind,
    input  logic [31:0] o_due_time,
    input  logic [15:0] o_out_type,
    input  logic signed [31:0] o_out_param_one,
    input  logic signed [31:0] o_out_param_two,
    input  logic [31:0] o_out_handle_one,
    input  logic [31:0] o_out_handle_two,
    input  logic        o_last,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [1:0] kind;
        t_entry     ev;
        logic       last;
    } t_outcome;

    t_entry   store_q[$];
    t_outcome awaited_q[$];
    int       fail_total = 0;

    assign o_fail_count = fail_total;

    function automatic t_outcome status_of(logic [1:0] kind);
        t_outcome r;
        r      = '0;
        r.kind = kind;
        r.last = 1'b1;
        return r;
    endfunction

    task automatic await_result(t_outcome r);
        awaited_q.insert(awaited_q.size(), r);
    endtask

    task automatic schedule_request(t_entry req, logic cmd);
        int pos;
        int n;
        t_outcome r;
        if (cmd == CMD_INSERT) begin
            if (store_q.size() >= Depth) begin
                await_result(status_of(KIND_FULL));
            end else begin
                pos = 0;
                while (pos < store_q.size() && store_q[pos].time_s <= req.time_s) pos++;
                store_q.insert(pos, req);
                await_result(status_of(KIND_ACCEPTED));
            end
        end else begin
            n = 0;
            while (n < store_q.size() && store_q[n].time_s <= req.time_s) n++;
            if (n == 0) await_result(status_of(KIND_NONE));
            for (int i = 0; i < n; i++) begin
                r.kind = KIND_DUE;
                r.ev   = store_q.pop_front();
                r.last = (i == n - 1);
                await_result(r);
            end
        end
    endtask

    task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (exp !== act) begin
            $error("%s: expected %0h, actual %0h", name, exp, act);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_entry   req;
        t_outcome e;
        if (i_rst_n && o_strobe) begin
            if (awaited_q.size() == 0) begin
                $error("unexpected result, kind %0d", o_kind);
                fail_total++;
            end else begin
                e = awaited_q.pop_front();
                check_field("kind", 32'(e.kind), 32'(o_kind));
                check_field("due_time", e.ev.time_s, o_due_time);
                check_field("out_type", 32'(e.ev.ev_type), 32'(o_out_type));
                check_field("out_param_one", e.ev.param_one, o_out_param_one);
                check_field("out_param_two", e.ev.param_two, o_out_param_two);
                check_field("out_handle_one", e.ev.handle_one, o_out_handle_one);
                check_field("out_handle_two", e.ev.handle_two, o_out_handle_two);
                check_field("last", 32'(e.last), 32'(o_last));
            end
        end
        if (i_rst_n && start && !busy) begin
            req = {i_event_time, i_event_type, i_param_one, i_param_two,
                   i_handle_one, i_handle_two};
            schedule_request(req, i_command);
        end
        o_pending = awaited_q.size();
    end

endmodule

// ===== dv/tb_timed_event_queue.sv =====
// Testbench top for the timed event queue: clock, reset and request stimulus.
// Depends on teq_pkg, timed_event_queue and teq_checker.
`timescale 1ns / 100ps
module tb_timed_event_queue;
    import teq_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_command = CMD_INSERT;
    logic [31:0] i_event_time = '0;
    logic [15:0] i_event_type = '0;
    logic signed [31:0] i_param_one = '0;
    logic signed [31:0] i_param_two = '0;
    logic [31:0] i_handle_one = '0;
    logic [31:0] i_handle_two = '0;
    logic        o_strobe;
    logic [1:0]  o_kind;
    logic [31:0] o_due_time;
    logic [15:0] o_out_type;
    logic signed [31:0] o_out_param_one;
    logic signed [31:0] o_out_param_two;
    logic [31:0] o_out_handle_one;
    logic [31:0] o_out_handle_two;
    logic        o_last;
    int          fail_count;
    int          pending;
    logic [31:0] clock_now;

    always #10 i_clk = ~i_clk;

    timed_event_queue DUT (.*);

    teq_checker u_checker (
        .*,
        .o_fail_count(fail_count),
        .o_pending(pending)
    );

    // The request stays on the ports after acceptance until the next idle gap or drain.
    task automatic send_request(logic cmd, logic [31:0] t, bit full_rand);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_command    <= cmd;
        i_event_time <= t;
        i_event_type <= full_rand ? 16'($urandom) : 16'($urandom_range(0, 15));
        i_param_one  <= $urandom;
        i_param_two  <= $urandom;
        i_handle_one <= $urandom;
        i_handle_two <= $urandom;
        start        <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic drain_results;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(CMD_TICK, 32'hFFFF_FFFF, 1'b1);
        send_request(CMD_INSERT, 32'hFFFF_FFFF, 1'b1);
        send_request(CMD_INSERT, 32'd0, 1'b1);
        send_request(CMD_INSERT, 32'd5, 1'b1);
        send_request(CMD_INSERT, 32'd5, 1'b1);
        send_request(CMD_INSERT, 32'd5, 1'b1);
        send_request(CMD_INSERT, 32'd3, 1'b1);
        send_request(CMD_TICK, 32'd0, 1'b1);
        send_request(CMD_TICK, 32'd4, 1'b1);
        send_request(CMD_TICK, 32'd5, 1'b1);
        send_request(CMD_TICK, 32'hFFFF_FFFE, 1'b1);
        send_request(CMD_TICK, 32'hFFFF_FFFF, 1'b1);
        // Fill the store beyond capacity, then release all in one tick.
        for (int i = 0; i < QueueDepthDefault + 2; i++)
            send_request(CMD_INSERT, $urandom_range(0, 40), 1'b1);
        drain_results();
        send_request(CMD_TICK, 32'hFFFF_FFFF, 1'b1);
        drain_results();

        clock_now = 32'd1000;
        for (int i = 0; i < 270; i++) begin
            if ($urandom_range(0, 2) == 0) begin
                clock_now = clock_now + $urandom_range(0, 30);
                send_request(CMD_TICK, clock_now, 1'b0);
            end else if ($urandom_range(0, 9) == 0) begin
                send_request(CMD_INSERT, $urandom, 1'b1);
            end else begin
                send_request(CMD_INSERT, clock_now + $urandom_range(0, 40), 1'b1);
            end
            if (i % 90 == 89) drain_results();
        end
        send_request(CMD_TICK, 32'hFFFF_FFFF, 1'b1);

        drain_results();
        repeat (300) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
